// ===== hdl/tsf_pkg.sv =====
// Shared types and constants for the Taylor-series function unit.
package tsf_pkg;

  localparam int TW = 60;
  localparam int MW = 41;
  localparam int PW = 101;
  localparam int AW = 63;
  localparam int RSH = 40;
  localparam int VW = 48;

  localparam logic [TW-1:0] TCAP = {TW{1'b1}};
  localparam logic signed [63:0] ACC_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [AW-1:0] OUT_MAX = AW'(64'sh0000_7FFF_FFFF_FFFF);
  localparam logic signed [AW-1:0] OUT_MIN = AW'(-64'sh0000_8000_0000_0000);

  typedef enum logic [2:0] {
    KIND_EXP  = 3'd0,
    KIND_SIN  = 3'd1,
    KIND_COS  = 3'd2,
    KIND_SINH = 3'd3,
    KIND_COSH = 3'd4,
    KIND_ATAN = 3'd5
  } kind_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           kind;
    logic                 zero_out;
    logic                 sat;
    logic                 mneg;
    logic [MW-1:0]        mmag;
    logic                 tneg;
    logic [TW-1:0]        tmag;
    logic signed [AW-1:0] acc;
  } ctx_t;

endpackage

// ===== hdl/tsf_mul.sv =====
// Two-stage rounding, saturating magnitude multiplier; operands are split at bit 32.
module tsf_mul import tsf_pkg::*; #(
  parameter int SHIFT = 32
) (
  input  logic          clk,
  input  logic [TW-1:0] a,
  input  logic [MW-1:0] b,
  output logic [TW-1:0] res_r,
  output logic          sat_r
);

  logic [63:0]   p00_r;
  logic [40:0]   p01_r;
  logic [59:0]   p10_r;
  logic [36:0]   p11_r;
  logic [PW-1:0] full;
  logic [TW-1:0] res_nxt;
  logic          sat_nxt;

  always_ff @(posedge clk) begin
    p00_r <= 64'(a[31:0]) * 64'(b[31:0]);
    p01_r <= 41'(a[31:0]) * 41'(b[40:32]);
    p10_r <= 60'(a[59:32]) * 60'(b[31:0]);
    p11_r <= 37'(a[59:32]) * 37'(b[40:32]);
  end

  always_comb begin
    full = PW'(p00_r) + (PW'(p01_r) << 32) + (PW'(p10_r) << 32) + (PW'(p11_r) << 64)
         + (PW'(1) << (SHIFT - 1));
    sat_nxt = |full[PW-1:SHIFT+TW];
    res_nxt = sat_nxt ? TCAP : full[SHIFT+TW-1:SHIFT];
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sat_r <= sat_nxt;
  end

endmodule

// ===== hdl/tsf_prep.sv =====
// Input stages: magnitude, square and starting term of the series.
module tsf_prep import tsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [2:0]  kind,
  input  logic [31:0] x,
  output ctx_t        ctx_r
);

  logic        v1_r, v2_r;
  logic [2:0]  k1_r, k2_r;
  logic        n1_r, n2_r;
  logic [31:0] a1_r, a2_r;
  logic [63:0] sq_r;
  logic [63:0] sq_rnd;
  logic [35:0] xq;
  logic        one_start;
  ctx_t        ctx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    k1_r <= kind;
    n1_r <= x[31];
    a1_r <= x[31] ? (~x + 32'd1) : x;
    k2_r <= k1_r;
    n2_r <= n1_r;
    a2_r <= a1_r;
    sq_r <= 64'(a1_r) * 64'(a1_r);
  end

  always_comb begin
    sq_rnd = sq_r + (64'd1 << 23);
    xq = {a2_r, 4'b0000};
    one_start = (k2_r == KIND_EXP) || (k2_r == KIND_COS) || (k2_r == KIND_COSH);
    ctx_nxt.valid = v2_r;
    ctx_nxt.kind = k2_r;
    ctx_nxt.zero_out = (k2_r > KIND_ATAN);
    ctx_nxt.sat = 1'b0;
    if (k2_r == KIND_EXP) begin
      ctx_nxt.mmag = MW'(xq);
      ctx_nxt.mneg = n2_r;
    end else begin
      ctx_nxt.mmag = MW'(sq_rnd[63:24]);
      ctx_nxt.mneg = (k2_r == KIND_SIN) || (k2_r == KIND_COS) || (k2_r == KIND_ATAN);
    end
    ctx_nxt.tmag = one_start ? (TW'(1) << 32) : TW'(xq);
    ctx_nxt.tneg = !one_start && n2_r && (a2_r != 32'd0);
    ctx_nxt.acc = ctx_nxt.tneg ? -AW'(ctx_nxt.tmag) : AW'(ctx_nxt.tmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.valid <= 1'b0;
    end else begin
      ctx_r <= ctx_nxt;
    end
  end

endmodule

// ===== hdl/tsf_term.sv =====
// One series term: power step, reciprocal scaling and accumulation over five stages.
module tsf_term import tsf_pkg::*; #(
  parameter int IDX = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  ctx_t ctx_in,
  output ctx_t ctx_r
);

  localparam int N_EXP = IDX;
  localparam int N_SIN = (2 * IDX) * (2 * IDX + 1);
  localparam int N_COS = (2 * IDX) * (2 * IDX - 1);
  localparam int N_ATN = 2 * IDX + 1;
  localparam logic [MW-1:0] R_EXP = MW'(((64'd1 << RSH) + 64'(N_EXP / 2)) / 64'(N_EXP));
  localparam logic [MW-1:0] R_SIN = MW'(((64'd1 << RSH) + 64'(N_SIN / 2)) / 64'(N_SIN));
  localparam logic [MW-1:0] R_COS = MW'(((64'd1 << RSH) + 64'(N_COS / 2)) / 64'(N_COS));
  localparam logic [MW-1:0] R_ATN = MW'(((64'd1 << RSH) + 64'(N_ATN / 2)) / 64'(N_ATN));

  ctx_t             s1_r, s2_r, s3_r, s4_r;
  ctx_t             s3_nxt, out_nxt;
  logic [TW-1:0]    u, c;
  logic             usat, csat, cneg;
  logic [MW-1:0]    recip;
  logic signed [63:0] wide;
  logic             acc_sat;

  tsf_mul #(.SHIFT(32)) u_mul_pow (
    .clk   (clk),
    .a     (ctx_in.tmag),
    .b     (ctx_in.mmag),
    .res_r (u),
    .sat_r (usat)
  );

  always_comb begin
    s3_nxt = s2_r;
    s3_nxt.tmag = u;
    s3_nxt.tneg = (u != '0) && (s2_r.tneg != s2_r.mneg);
    s3_nxt.sat = s2_r.sat | usat;
    unique case (s2_r.kind)
      KIND_EXP:             recip = R_EXP;
      KIND_SIN, KIND_SINH:  recip = R_SIN;
      KIND_COS, KIND_COSH:  recip = R_COS;
      default:              recip = R_ATN;
    endcase
  end

  tsf_mul #(.SHIFT(RSH)) u_mul_rcp (
    .clk   (clk),
    .a     (u),
    .b     (recip),
    .res_r (c),
    .sat_r (csat)
  );

  always_comb begin
    cneg = s4_r.tneg && (c != '0);
    wide = cneg ? (64'(s4_r.acc) - signed'({4'b0000, c}))
                : (64'(s4_r.acc) + signed'({4'b0000, c}));
    out_nxt = s4_r;
    acc_sat = 1'b0;
    if (wide > ACC_LIM) begin
      acc_sat = 1'b1;
      out_nxt.acc = AW'(ACC_LIM);
    end else if (wide < -ACC_LIM) begin
      acc_sat = 1'b1;
      out_nxt.acc = AW'(-ACC_LIM);
    end else begin
      out_nxt.acc = wide[AW-1:0];
    end
    out_nxt.sat = s4_r.sat | csat | acc_sat;
    if (s4_r.kind != KIND_ATAN) begin
      out_nxt.tmag = c;
      out_nxt.tneg = cneg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      s3_r.valid  <= 1'b0;
      s4_r.valid  <= 1'b0;
      ctx_r.valid <= 1'b0;
    end else begin
      s1_r  <= ctx_in;
      s2_r  <= s1_r;
      s3_r  <= s3_nxt;
      s4_r  <= s3_r;
      ctx_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/tsf_clip.sv =====
// Output stage: clips the sum to Q16.32, zeroes it for unknown kinds and drives the result strobe.
module tsf_clip import tsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctx_t                 ctx_in,
  output logic                 valid_r,
  output logic signed [VW-1:0] value_r,
  output logic                 sat_r
);

  logic signed [VW-1:0] value_nxt;
  logic                 sat_nxt;

  always_comb begin
    if (ctx_in.zero_out) begin
      value_nxt = '0;
      sat_nxt = 1'b0;
    end else if (ctx_in.acc > OUT_MAX) begin
      value_nxt = OUT_MAX[VW-1:0];
      sat_nxt = 1'b1;
    end else if (ctx_in.acc < OUT_MIN) begin
      value_nxt = OUT_MIN[VW-1:0];
      sat_nxt = 1'b1;
    end else begin
      value_nxt = ctx_in.acc[VW-1:0];
      sat_nxt = ctx_in.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctx_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    sat_r <= sat_nxt;
  end

endmodule

// ===== hdl/taylor_series_function_unit.sv =====
// Top level of the Taylor-series function unit.
// An item passes from start through the input stages, TERMS-1 term blocks and the output register to out_valid.
// Throughput is one item per cycle; busy stays low since every stage advances each cycle.
// Each term takes five stages: two for the power multiply, two for the reciprocal, one to sum.
// Synchronous active-low reset clears the valid bits of every stage; payload is not reset.
module taylor_series_function_unit import tsf_pkg::*; #(
  parameter int TERMS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_kind,
  input  logic signed [31:0]   in_x,
  output logic                 out_valid,
  output logic signed [VW-1:0] out_value,
  output logic                 out_saturated
);

  localparam int LAT = 4 + 5 * (TERMS - 1);

  ctx_t chain [TERMS];

  assign busy = 1'b0;

  tsf_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (start),
    .kind  (in_kind),
    .x     (in_x),
    .ctx_r (chain[0])
  );

  for (genvar gi = 1; gi < TERMS; gi++) begin : g_term
    tsf_term #(.IDX(gi)) u_term (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctx_in (chain[gi-1]),
      .ctx_r  (chain[gi])
    );
  end

  tsf_clip u_clip (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctx_in  (chain[TERMS-1]),
    .valid_r (out_valid),
    .value_r (out_value),
    .sat_r   (out_saturated)
  );

`ifndef SYNTHESIS
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without an item accepted at the pipeline latency");

  a_reset_clears: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("result strobe right after reset");

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && $past(rst_n, 1)) |-> ##LAT (out_valid || !$past(rst_n, LAT - 1)))
    else $error("accepted item produced no result");
`endif

endmodule
